@@ hw/rtl/infix_to_postfix_converter_assert.svh @@
// assertion macros shared by the rtl files
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// condition holds at every edge out of reset
`define I2P_ASSERT_ALWAYS(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("i2p assertion failed");

// same-cycle implication
`define I2P_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2p assertion failed");

// next-cycle implication
`define I2P_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2p assertion failed");

`endif

@@ hw/rtl/i2p_pkg.sv @@
package i2p_pkg;

  localparam int KIND_W     = 3;
  localparam int PREC_W     = 4;
  localparam int OUT_KIND_W = 2;
  localparam int STATUS_W   = 2;

  // input token kinds
  localparam logic [KIND_W-1:0] KIND_OPERAND  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_END      = 3'd4;

  // result kinds
  localparam logic [OUT_KIND_W-1:0] OUT_OPERAND  = 2'd0;
  localparam logic [OUT_KIND_W-1:0] OUT_OPERATOR = 2'd1;
  localparam logic [OUT_KIND_W-1:0] OUT_MARKER   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_OPEN  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNCLOSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_CLEAR
  } stk_op_t;

endpackage

@@ hw/rtl/i2p_token_if.sv @@
interface i2p_token_if
  import i2p_pkg::*;
#(
  parameter int CODE_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     token_kind;
  logic [CODE_WIDTH-1:0] token_code;
  logic [PREC_W-1:0]     precedence;

  modport source (output valid, token_kind, token_code, precedence, input ready);
  modport sink   (input valid, token_kind, token_code, precedence, output ready);
endinterface

@@ hw/rtl/i2p_result_if.sv @@
interface i2p_result_if
  import i2p_pkg::*;
#(
  parameter int CODE_WIDTH = 16
);
  logic                  valid;
  logic                  ready;
  logic [OUT_KIND_W-1:0] out_kind;
  logic [CODE_WIDTH-1:0] out_code;
  logic [STATUS_W-1:0]   status;
  logic                  last;

  modport source (output valid, out_kind, out_code, status, last, input ready);
  modport sink   (input valid, out_kind, out_code, status, last, output ready);
endinterface

@@ hw/rtl/i2p_cell.sv @@
module i2p_cell
  import i2p_pkg::*;
#(
  parameter int WIDTH = 21
) (
  input  logic             clk,
  input  stk_op_t          op,
  input  logic [WIDTH-1:0] above,
  input  logic [WIDTH-1:0] below,
  output logic [WIDTH-1:0] entry
);

  // push takes the neighbor above, pop takes the neighbor below
  always_ff @(posedge clk) begin
    unique case (op)
      STK_PUSH: entry <= above;
      STK_POP:  entry <= below;
      default:  entry <= entry;
    endcase
  end

endmodule

@@ hw/rtl/i2p_stack.sv @@
module i2p_stack
  import i2p_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int WIDTH = 21,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  stk_op_t          op,
  input  logic [WIDTH-1:0] push_data,
  output logic [WIDTH-1:0] top_entry,
  output logic [WIDTH-1:0] next_entry,
  output logic [CNT_W-1:0] count,
  output logic             full,
  output logic             empty
);

  `include "infix_to_postfix_converter_assert.svh"

  logic [WIDTH-1:0] entries [DEPTH];

  // cell 0 is the top of stack
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] above;
    logic [WIDTH-1:0] below;
    if (i == 0) begin : g_top
      assign above = push_data;
    end else begin : g_mid
      assign above = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_up
      assign below = entries[i+1];
    end
    i2p_cell #(.WIDTH(WIDTH)) u_cell (
      .clk   (clk),
      .op    (op),
      .above (above),
      .below (below),
      .entry (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (op)
        STK_PUSH:  count <= count + CNT_W'(1);
        STK_POP:   count <= count - CNT_W'(1);
        STK_CLEAR: count <= '0;
        default:   count <= count;
      endcase
    end
  end

  assign top_entry  = entries[0];
  assign next_entry = entries[1];
  assign full       = (count == CNT_W'(DEPTH));
  assign empty      = (count == '0);

  `I2P_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `I2P_ASSERT_IMPLY(a_no_push_full, clk, rst, op == STK_PUSH, !full)
  `I2P_ASSERT_IMPLY(a_no_pop_empty, clk, rst, op == STK_POP, !empty)

endmodule

@@ hw/rtl/infix_to_postfix_converter.sv @@
// channel  | dir | payload                                   | transfer
// token    | in  | token_kind, token_code, precedence        | valid && ready
// result   | out | out_kind, out_code, status, last          | valid && ready
//
// an item is accepted while idle and then worked off in stack steps:
// operand and open paren finish in their first step, operator/close/end pop
// entries first; the stack is a chain of one-entry cells, push/pop shift one
// place per cycle; rst is synchronous, it empties the stack and drops any
// pending result; a step waits while the result register is full and not taken
module infix_to_postfix_converter
  import i2p_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int CODE_WIDTH  = 16
) (
  input logic           clk,
  input logic           rst,
  i2p_token_if.sink     token,
  i2p_result_if.source  result
);

  `include "infix_to_postfix_converter_assert.svh"

  localparam int ENTRY_W = 1 + PREC_W + CODE_WIDTH;
  localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_t;

  state_t                state;
  logic [KIND_W-1:0]     cmd_kind;
  logic [CODE_WIDTH-1:0] cmd_code;
  logic [PREC_W-1:0]     cmd_prec;
  logic                  popping;

  logic                  res_valid;
  logic [OUT_KIND_W-1:0] res_kind;
  logic [CODE_WIDTH-1:0] res_code;
  logic [STATUS_W-1:0]   res_status;
  logic                  res_last;

  stk_op_t               stk_op;
  logic [ENTRY_W-1:0]    push_data;
  logic [ENTRY_W-1:0]    top_entry;
  logic [ENTRY_W-1:0]    next_entry;
  logic [CNT_W-1:0]      stk_count;
  logic                  stk_full;
  logic                  stk_empty;

  logic                  out_free;
  logic                  step;
  logic                  emit;
  logic [OUT_KIND_W-1:0] e_kind;
  logic [CODE_WIDTH-1:0] e_code;
  logic [STATUS_W-1:0]   e_status;
  logic                  e_last;
  logic                  done;
  logic                  set_popping;

  logic                  top_mark;
  logic [PREC_W-1:0]     head_prec;
  logic [CODE_WIDTH-1:0] top_code;
  logic                  nxt_mark;
  logic [PREC_W-1:0]     nxt_prec;
  logic                  has_next;
  logic                  op_pop;
  logic                  accept;

  i2p_stack #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (ENTRY_W),
    .CNT_W (CNT_W)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .op         (stk_op),
    .push_data  (push_data),
    .top_entry  (top_entry),
    .next_entry (next_entry),
    .count      (stk_count),
    .full       (stk_full),
    .empty      (stk_empty)
  );

  assign top_mark  = top_entry[ENTRY_W-1];
  assign head_prec = top_entry[ENTRY_W-2 -: PREC_W];
  assign top_code  = top_entry[CODE_WIDTH-1:0];
  assign nxt_mark  = next_entry[ENTRY_W-1];
  assign nxt_prec  = next_entry[ENTRY_W-2 -: PREC_W];
  assign has_next  = (stk_count > CNT_W'(1));

  // first pop needs a strictly higher top, later pops take equal too
  assign op_pop = !stk_empty && !top_mark &&
                  (popping ? (head_prec >= cmd_prec) : (head_prec > cmd_prec));

  assign out_free = !res_valid || result.ready;
  assign step     = (state == S_WORK) && out_free;
  assign accept   = token.valid && token.ready;

  always_comb begin
    stk_op      = STK_HOLD;
    push_data   = '0;
    emit        = 1'b0;
    e_kind      = OUT_MARKER;
    e_code      = '0;
    e_status    = ST_OK;
    e_last      = 1'b0;
    done        = 1'b0;
    set_popping = 1'b0;
    if (step) begin
      unique case (cmd_kind)
        KIND_OPERAND: begin
          emit   = 1'b1;
          e_kind = OUT_OPERAND;
          e_code = cmd_code;
          e_last = 1'b1;
          done   = 1'b1;
        end
        KIND_OPERATOR: begin
          if (op_pop) begin
            stk_op      = STK_POP;
            emit        = 1'b1;
            e_kind      = OUT_OPERATOR;
            e_code      = top_code;
            // last pop when the entry below stops the run
            e_last      = !has_next || nxt_mark || (nxt_prec < cmd_prec);
            set_popping = 1'b1;
          end else if (stk_full) begin
            stk_op   = STK_CLEAR;
            emit     = 1'b1;
            e_status = ST_OVERFLOW;
            e_last   = 1'b1;
            done     = 1'b1;
          end else begin
            stk_op    = STK_PUSH;
            push_data = {1'b0, cmd_prec, cmd_code};
            done      = 1'b1;
          end
        end
        KIND_OPEN: begin
          if (stk_full) begin
            stk_op   = STK_CLEAR;
            emit     = 1'b1;
            e_status = ST_OVERFLOW;
            e_last   = 1'b1;
          end else begin
            stk_op    = STK_PUSH;
            push_data = {1'b1, {PREC_W{1'b0}}, {CODE_WIDTH{1'b0}}};
          end
          done = 1'b1;
        end
        KIND_CLOSE: begin
          if (stk_empty) begin
            emit     = 1'b1;
            e_status = ST_NO_OPEN;
            e_last   = 1'b1;
            done     = 1'b1;
          end else if (top_mark) begin
            stk_op = STK_POP;
            done   = 1'b1;
          end else begin
            stk_op = STK_POP;
            emit   = 1'b1;
            e_kind = OUT_OPERATOR;
            e_code = top_code;
            e_last = has_next && nxt_mark;
          end
        end
        KIND_END: begin
          if (stk_empty) begin
            emit   = 1'b1;
            e_last = 1'b1;
            done   = 1'b1;
          end else if (top_mark) begin
            stk_op   = STK_CLEAR;
            emit     = 1'b1;
            e_status = ST_UNCLOSED;
            e_last   = 1'b1;
            done     = 1'b1;
          end else begin
            stk_op = STK_POP;
            emit   = 1'b1;
            e_kind = OUT_OPERATOR;
            e_code = top_code;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      popping   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (accept) begin
        cmd_kind <= token.token_kind;
        cmd_code <= token.token_code;
        cmd_prec <= token.precedence;
        // unknown kinds are dropped at the door
        if (token.token_kind <= KIND_END) begin
          state <= S_WORK;
        end
      end else if (done) begin
        state   <= S_IDLE;
        popping <= 1'b0;
      end else if (set_popping) begin
        popping <= 1'b1;
      end

      if (emit) begin
        res_valid  <= 1'b1;
        res_kind   <= e_kind;
        res_code   <= e_code;
        res_status <= e_status;
        res_last   <= e_last;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign token.ready     = (state == S_IDLE);
  assign result.valid    = res_valid;
  assign result.out_kind = res_kind;
  assign result.out_code = res_code;
  assign result.status   = res_status;
  assign result.last     = res_last;

  `I2P_ASSERT_IMPLY(a_err_is_final_marker, clk, rst,
    result.valid && result.status != ST_OK,
    result.out_kind == OUT_MARKER && result.last)
  `I2P_ASSERT_NEXT(a_err_empties_stack, clk, rst,
    emit && e_status != ST_OK, stk_count == '0)
  `I2P_ASSERT_IMPLY(a_token_ok_status, clk, rst,
    result.valid && result.out_kind != OUT_MARKER, result.status == ST_OK)

endmodule
